/* hdl/avf_pkg.sv */
package avf_pkg;

  localparam int CFG_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_COMPANY_ID = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRY_MS  = 2'd1;

  localparam logic [15:0] COMPANY_RESET   = 16'h02E1;
  localparam logic [39:0] EXPIRY_RESET    = 40'd300000;
  localparam logic [7:0]  NEW_HEADER_MARK = 8'h10;
  localparam logic [4:0]  MIN_MFG_LEN     = 5'd15;
  localparam logic [4:0]  NEW_MFG_LEN     = 5'd18;

  localparam logic [1:0] REQ_ADVERT = 2'd0;
  localparam logic [1:0] REQ_LOOKUP = 2'd1;
  localparam logic [1:0] REQ_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    STAT_REJECTED = 3'd0,
    STAT_UPDATED  = 3'd1,
    STAT_NEW_SLOT = 3'd2,
    STAT_EVICTED  = 3'd3,
    STAT_HIT      = 3'd4,
    STAT_MISS     = 3'd5,
    STAT_COUNT    = 3'd6
  } avf_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } avf_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] sender_address;
    logic [4:0]  mfg_length;
    logic [63:0] mfg_head;
    logic [39:0] now_ms;
  } avf_in_t;

  typedef struct packed {
    avf_status_t status;
    logic [5:0]  slot_index;
    logic        new_format;
    logic [7:0]  record_kind;
    logic [15:0] nonce_value;
    logic [39:0] seen_time;
    logic [6:0]  active_count;
  } avf_out_t;

  typedef struct packed {
    logic [47:0] address;
    logic [39:0] seen_time;
    logic [7:0]  record_kind;
    logic [15:0] nonce;
  } avf_slot_t;

endpackage

/* hdl/advert_filter_device_table.sv */
// Channel  Direction  Handshake                 Payload
// in_      input      in_valid / in_stall       avf_pkg::avf_in_t
// out_     output     out_valid / out_stall     avf_pkg::avf_out_t
// cfg_     input      cfg_we, cfg_index         cfg_wdata (40 bits)
//
// One transaction at a time: accept, then walk the slot memory one entry per
// cycle through its registered read port, then write back and register the result.
// A hit ends the walk early for adverts and lookups; an empty table, a rejected
// advertisement or an unknown request skips the walk and goes straight to finish.
// Reset clears control, used_slots, the config and out_valid; slot contents and data registers stay undefined.
// The result register lets the next transaction enter while a result is stalled.
module advert_filter_device_table #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  avf_pkg::avf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output avf_pkg::avf_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [avf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [avf_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  avf_pkg::avf_state_t state_r, state_nxt;
  avf_pkg::avf_in_t    item_r;
  avf_pkg::avf_slot_t  mem [SLOT_COUNT];
  avf_pkg::avf_slot_t  rdata_r;
  avf_pkg::avf_slot_t  hit_ent_r;
  avf_pkg::avf_slot_t  wr_ent;
  avf_pkg::avf_out_t   out_data_r;
  avf_pkg::avf_out_t   res;

  logic [15:0]    company_r;
  logic [39:0]    expiry_r;
  logic [CW-1:0]  used_r;
  logic [CW-1:0]  rd_idx_r;
  logic [IW-1:0]  cmp_idx_r;
  logic           pend_r;
  logic           found_r;
  logic [IW-1:0]  hit_idx_r;
  logic [IW-1:0]  min_idx_r;
  logic [39:0]    min_seen_r;
  logic [CW-1:0]  count_r;
  logic           out_valid_r;

  logic           in_accept;
  logic           adv_ok;
  logic           new_fmt;
  logic [7:0]     kind;
  logic [15:0]    nonce;
  logic           skip;
  logic           issue;
  logic           ent_match;
  logic           match;
  logic           ent_active;
  logic           ent_min;
  logic [39:0]    age;
  logic           has_free;
  logic           load;
  logic           wr_en;
  logic [IW-1:0]  wr_idx;
  logic           grow;

  assign in_stall  = (state_r != avf_pkg::S_IDLE);
  assign in_accept = in_valid && (state_r == avf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // header parse
  always_comb begin
    adv_ok  = (item_r.mfg_length >= avf_pkg::MIN_MFG_LEN) &&
              (item_r.mfg_head[15:0] == company_r);
    new_fmt = (item_r.mfg_head[23:16] == avf_pkg::NEW_HEADER_MARK) &&
              (item_r.mfg_length >= avf_pkg::NEW_MFG_LEN);
    kind    = new_fmt ? item_r.mfg_head[47:40] : item_r.mfg_head[23:16];
    nonce   = new_fmt ? item_r.mfg_head[63:48] : item_r.mfg_head[39:24];
    skip    = ((item_r.req_type == avf_pkg::REQ_ADVERT) && !adv_ok) ||
              ((item_r.req_type != avf_pkg::REQ_ADVERT) &&
               (item_r.req_type != avf_pkg::REQ_LOOKUP) &&
               (item_r.req_type != avf_pkg::REQ_COUNT));
  end

  // scan compare
  always_comb begin
    issue      = (state_r == avf_pkg::S_SCAN) && !skip && (rd_idx_r < used_r);
    ent_match  = pend_r && (rdata_r.address == item_r.sender_address);
    match      = ent_match && (item_r.req_type != avf_pkg::REQ_COUNT);
    age        = item_r.now_ms - rdata_r.seen_time;
    ent_active = pend_r && ((item_r.now_ms < rdata_r.seen_time) || (age < expiry_r));
    ent_min    = pend_r && ((cmp_idx_r == '0) || (rdata_r.seen_time < min_seen_r));
    has_free   = (used_r < CW'(SLOT_COUNT));
  end

  // result and write-back
  always_comb begin
    res    = '0;
    wr_idx = '0;
    grow   = 1'b0;
    case (item_r.req_type)
      avf_pkg::REQ_ADVERT: begin
        if (!skip) begin
          if (found_r) begin
            res.status = avf_pkg::STAT_UPDATED;
            wr_idx     = hit_idx_r;
          end else if (has_free) begin
            res.status = avf_pkg::STAT_NEW_SLOT;
            wr_idx     = used_r[IW-1:0];
            grow       = 1'b1;
          end else begin
            res.status = avf_pkg::STAT_EVICTED;
            wr_idx     = min_idx_r;
          end
          res.slot_index  = 6'(wr_idx);
          res.new_format  = new_fmt;
          res.record_kind = kind;
          res.nonce_value = nonce;
          res.seen_time   = item_r.now_ms;
        end
      end
      avf_pkg::REQ_LOOKUP: begin
        if (found_r) begin
          res.status      = avf_pkg::STAT_HIT;
          res.slot_index  = 6'(hit_idx_r);
          res.record_kind = hit_ent_r.record_kind;
          res.nonce_value = hit_ent_r.nonce;
          res.seen_time   = hit_ent_r.seen_time;
        end else begin
          res.status = avf_pkg::STAT_MISS;
        end
      end
      avf_pkg::REQ_COUNT: begin
        res.status       = avf_pkg::STAT_COUNT;
        res.active_count = 7'(count_r);
      end
      default: begin
        res.status = avf_pkg::STAT_REJECTED;
      end
    endcase
    wr_ent.address     = item_r.sender_address;
    wr_ent.seen_time   = item_r.now_ms;
    wr_ent.record_kind = kind;
    wr_ent.nonce       = nonce;
  end

  assign load  = (state_r == avf_pkg::S_FINISH) && (!out_valid_r || !out_stall);
  assign wr_en = load && (item_r.req_type == avf_pkg::REQ_ADVERT) && !skip;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      avf_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = avf_pkg::S_SCAN;
        end
      end
      avf_pkg::S_SCAN: begin
        if (skip || match || (!issue && !pend_r)) begin
          state_nxt = avf_pkg::S_FINISH;
        end
      end
      avf_pkg::S_FINISH: begin
        if (load) begin
          state_nxt = avf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = avf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= avf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      company_r <= avf_pkg::COMPANY_RESET;
      expiry_r  <= avf_pkg::EXPIRY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        avf_pkg::CFG_COMPANY_ID: company_r <= cfg_wdata[15:0];
        avf_pkg::CFG_EXPIRY_MS:  expiry_r  <= cfg_wdata[39:0];
        default: ;
      endcase
    end
  end

  // scan control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      rd_idx_r <= '0;
      pend_r   <= 1'b0;
      found_r  <= 1'b0;
      count_r  <= '0;
    end else begin
      if (in_accept) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
        found_r  <= 1'b0;
        count_r  <= '0;
      end else if (state_r == avf_pkg::S_SCAN) begin
        if (issue) begin
          rd_idx_r <= rd_idx_r + 1'b1;
        end
        pend_r <= issue;
        if (match) begin
          found_r <= 1'b1;
        end
        if (ent_active) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (wr_en && grow) begin
        used_r <= used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (state_r == avf_pkg::S_SCAN) begin
      cmp_idx_r <= rd_idx_r[IW-1:0];
      if (match) begin
        hit_idx_r <= cmp_idx_r;
        hit_ent_r <= rdata_r;
      end
      if (ent_min) begin
        min_idx_r  <= cmp_idx_r;
        min_seen_r <= rdata_r.seen_time;
      end
    end
  end

  // slot memory: write-back in finish, reads only during scan
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_ent;
    end
    if (issue) begin
      rdata_r <= mem[rd_idx_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= res;
    end
  end

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(SLOT_COUNT))
    else $error("used slot count beyond table size");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && state_r == avf_pkg::S_SCAN) |-> (CW'(cmp_idx_r) < used_r))
    else $error("compare of an unused slot");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_valid_r && state_r == avf_pkg::S_IDLE))
    else $error("result load did not return to idle");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == avf_pkg::S_SCAN))
    else $error("accepted transaction did not start a scan");

  a_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && grow) |=> (used_r == CW'($past(used_r) + 1'b1)))
    else $error("new slot did not advance used count");

endmodule
